@@ rtl/core/tsc_pkg.sv @@
// Shared types, status codes and register indexes for the TSC charge spreader.
`default_nettype none
package tsc_pkg;

	typedef struct packed {
		logic               func;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] charge;
		logic        [4:0]  cell_x;
		logic        [4:0]  cell_y;
		logic        [4:0]  cell_z;
	} tsc_in_t;

	typedef struct packed {
		logic signed [47:0] cell_value;
		logic        [1:0]  status;
	} tsc_out_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	localparam logic FUNC_SPREAD = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	localparam logic [2:0] REG_GRID_X = 3'd0;
	localparam logic [2:0] REG_GRID_Y = 3'd1;
	localparam logic [2:0] REG_GRID_Z = 3'd2;
	localparam logic [2:0] REG_INV_X  = 3'd3;
	localparam logic [2:0] REG_INV_Y  = 3'd4;
	localparam logic [2:0] REG_INV_Z  = 3'd5;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_AX_MT,
		S_AX_IU,
		S_AX_M0,
		S_AX_MD,
		S_AX_M2,
		S_AX_W2,
		S_CHK,
		S_C_XY,
		S_C_Z,
		S_C_Q,
		S_C_WR,
		S_RD,
		S_RD_WR,
		S_DONE
	} tsc_state_t;

endpackage
`default_nettype wire

@@ rtl/core/tsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tsc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32768
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire                      re,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/tsc_mul.sv @@
// Shared 33x33 signed multiplier with registered product.
`default_nettype none
module tsc_mul (
	input  wire                      clk,
	input  wire  signed [32:0]       a,
	input  wire  signed [32:0]       b,
	output logic signed [65:0]       prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule
`default_nettype wire

@@ rtl/core/tsc_charge_spread_unit.sv @@
// TSC charge spreader top level: sequencer, axis weights and grid accumulation.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | in_data (tsc_in_t)
//  out     | output    | out_valid/out_stall | out_data (tsc_out_t)
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// After the transaction is taken a spread keeps in_stall high through three axis setups
// (states S_AX_MT to S_AX_W2 each), one range check, S_C_XY, S_C_Z, S_C_Q and S_C_WR per
// cell for 27 cells and one hand-off. A dropped position ends after the range check, a
// read-and-clear runs S_RD and S_RD_WR, a zero charge goes to the hand-off. After reset
// the grid is cleared one cell a cycle while in_stall stays high; configuration is taken.
// The finished result waits in the output register; the next transaction is accepted
// meanwhile, and the sequencer holds only if that register is still full.
`default_nettype none
module tsc_charge_spread_unit
	import tsc_pkg::*;
#(
	parameter int GRID_DIM_MAX = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  tsc_in_t     in_data,
	output logic        out_valid,
	input  wire         out_stall,
	output tsc_out_t    out_data,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [31:0] cfg_data
);

	localparam int DEPTH = GRID_DIM_MAX * GRID_DIM_MAX * GRID_DIM_MAX;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(GRID_DIM_MAX);

	function automatic logic [5:0] eff_size(input logic [5:0] s);
		logic [5:0] r;
		r = s;
		if (s < 6'd4) begin
			r = 6'd4;
		end else if ({2'b0, s} > 8'(GRID_DIM_MAX)) begin
			r = 6'(GRID_DIM_MAX);
		end
		return r;
	endfunction

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] g, input logic [5:0] n);
		logic [IW-1:0] r;
		r = g + 1'b1;
		if (8'(g) == 8'(n) - 8'd1) begin
			r = '0;
		end
		return r;
	endfunction

	function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] g, input logic [5:0] n);
		logic [IW-1:0] r;
		r = g - 1'b1;
		if (g == '0) begin
			r = IW'(n - 6'd1);
		end
		return r;
	endfunction

	tsc_state_t state_q, state_d;

	logic [5:0]  gsx_q, gsy_q, gsz_q;
	logic [31:0] invx_q, invy_q, invz_q;

	tsc_in_t     item_q;
	logic [31:0] qm_q;
	logic        qneg_q;
	logic [1:0]  ax_q;
	logic        ok_q;
	logic [29:0] u_q;
	logic [30:0] w0_q, w1_q;
	logic [30:0] wt_q [3][3];
	logic [IW-1:0] cell_q [3];
	logic [IW-1:0] gx_q, gy_q, gz_q;
	logic [1:0]  ca_q, cb_q, cc_q;
	logic [1:0]  status_q;
	logic signed [47:0] value_q;
	logic [AW-1:0] clr_q;
	logic        out_valid_q;
	tsc_out_t    out_q;

	logic [5:0]  nx, ny, nz, n_sel;
	logic [31:0] pos_sel, inv_sel;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	logic        accept, out_load;
	logic        rd_inside;
	logic [AW-1:0] addr_sp, addr_rd, ram_addr;
	logic        ram_we, ram_re;
	logic [47:0] ram_wdata, rd_data;

	logic [63:0] v;
	logic signed [33:0] i34, n34, ii;
	logic        ax_ok;
	logic [30:0] om;
	logic signed [30:0] dsig;
	logic [29:0] dmag;
	logic [29:0] d2;
	logic [29:0] dep;
	logic signed [48:0] dep49, sum49;
	logic        sat_hi, sat_lo;
	logic [47:0] acc_new;
	logic [IW-1:0] gy0, gz0;

	assign nx = eff_size(gsx_q);
	assign ny = eff_size(gsy_q);
	assign nz = eff_size(gsz_q);

	always_comb begin
		case (ax_q)
			2'd0: begin
				pos_sel = item_q.pos_x;
				inv_sel = invx_q;
				n_sel   = nx;
			end
			2'd1: begin
				pos_sel = item_q.pos_y;
				inv_sel = invy_q;
				n_sel   = ny;
			end
			default: begin
				pos_sel = item_q.pos_z;
				inv_sel = invz_q;
				n_sel   = nz;
			end
		endcase
	end

	// axis arithmetic
	assign v    = prod[63:0] + 64'h0000_0000_8000_0000;
	assign i34  = {{2{v[63]}}, v[63:32]};
	assign n34  = {28'b0, n_sel};
	always_comb begin
		if (i34 < 0) begin
			ii = i34 + n34;
		end else if (i34 >= n34) begin
			ii = i34 - n34;
		end else begin
			ii = i34;
		end
	end
	assign ax_ok = !ii[33] && (ii < n34);
	assign om    = 31'h4000_0000 - {1'b0, u_q};
	assign dsig  = $signed({1'b0, u_q}) - 31'sh2000_0000;
	assign dmag  = dsig[30] ? 30'(-dsig) : dsig[29:0];
	assign d2    = prod[59:30];

	// cell accumulation
	assign dep    = prod[59:30];
	assign dep49  = qneg_q ? -$signed({19'b0, dep}) : $signed({19'b0, dep});
	assign sum49  = $signed({rd_data[47], rd_data}) + dep49;
	assign sat_hi = !sum49[48] && sum49[47];
	assign sat_lo = sum49[48] && !sum49[47];
	assign acc_new = sat_hi ? 48'h7FFF_FFFF_FFFF : (sat_lo ? 48'h8000_0000_0000 : sum49[47:0]);

	assign gy0 = wrap_dec(cell_q[1], ny);
	assign gz0 = wrap_dec(cell_q[2], nz);

	assign addr_sp = AW'((AW'(gx_q) * AW'(GRID_DIM_MAX) + AW'(gy_q)) * AW'(GRID_DIM_MAX)
		+ AW'(gz_q));
	assign addr_rd = AW'((AW'(item_q.cell_x) * AW'(GRID_DIM_MAX) + AW'(item_q.cell_y))
		* AW'(GRID_DIM_MAX) + AW'(item_q.cell_z));
	assign rd_inside = (8'(in_data.cell_x) < 8'(GRID_DIM_MAX))
		&& (8'(in_data.cell_y) < 8'(GRID_DIM_MAX))
		&& (8'(in_data.cell_z) < 8'(GRID_DIM_MAX));

	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		mul_a     = '0;
		mul_b     = '0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = (item_q.func == FUNC_READ) ? addr_rd : addr_sp;
		ram_wdata = '0;
		case (state_q)
			S_CLR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (in_data.func == FUNC_READ) begin
						state_d = rd_inside ? S_RD : S_DONE;
					end else begin
						state_d = (in_data.charge == '0) ? S_DONE : S_AX_MT;
					end
				end
			end
			S_AX_MT: begin
				mul_a   = {pos_sel[31], pos_sel};
				mul_b   = {1'b0, inv_sel};
				state_d = S_AX_IU;
			end
			S_AX_IU: begin
				state_d = S_AX_M0;
			end
			S_AX_M0: begin
				mul_a   = {2'b0, om};
				mul_b   = {2'b0, om};
				state_d = S_AX_MD;
			end
			S_AX_MD: begin
				mul_a   = {3'b0, dmag};
				mul_b   = {3'b0, dmag};
				state_d = S_AX_M2;
			end
			S_AX_M2: begin
				mul_a   = {3'b0, u_q};
				mul_b   = {3'b0, u_q};
				state_d = S_AX_W2;
			end
			S_AX_W2: begin
				state_d = (ax_q == 2'd2) ? S_CHK : S_AX_MT;
			end
			S_CHK: begin
				state_d = ok_q ? S_C_XY : S_DONE;
			end
			S_C_XY: begin
				mul_a   = {2'b0, wt_q[0][0]};
				mul_b   = {2'b0, wt_q[1][0]};
				ram_re  = 1'b1;
				state_d = S_C_Z;
			end
			S_C_Z: begin
				mul_a   = {1'b0, prod[61:30]};
				mul_b   = {2'b0, wt_q[2][0]};
				state_d = S_C_Q;
			end
			S_C_Q: begin
				mul_a   = {1'b0, qm_q};
				mul_b   = {4'b0, prod[61:33]};
				state_d = S_C_WR;
			end
			S_C_WR: begin
				ram_we    = 1'b1;
				ram_wdata = acc_new;
				state_d   = (ca_q == 2'd2 && cb_q == 2'd2 && cc_q == 2'd2) ? S_DONE : S_C_XY;
			end
			S_RD: begin
				ram_re  = 1'b1;
				state_d = S_RD_WR;
			end
			S_RD_WR: begin
				ram_we  = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gsx_q  <= 6'd32;
			gsy_q  <= 6'd32;
			gsz_q  <= 6'd32;
			invx_q <= 32'd65536;
			invy_q <= 32'd65536;
			invz_q <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_X: gsx_q  <= cfg_data[5:0];
				REG_GRID_Y: gsy_q  <= cfg_data[5:0];
				REG_GRID_Z: gsz_q  <= cfg_data[5:0];
				REG_INV_X:  invx_q <= cfg_data;
				REG_INV_Y:  invy_q <= cfg_data;
				REG_INV_Z:  invz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.cell_value <= value_q;
			out_q.status     <= status_q;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q   <= in_data;
					qm_q     <= in_data.charge[31] ? 32'(-in_data.charge) : in_data.charge;
					qneg_q   <= in_data.charge[31];
					ax_q     <= 2'd0;
					ok_q     <= 1'b1;
					status_q <= ST_OK;
					value_q  <= '0;
				end
			end
			S_AX_IU: begin
				ok_q         <= ok_q && ax_ok;
				cell_q[ax_q] <= ii[IW-1:0];
				u_q          <= v[31:2];
			end
			S_AX_MD: begin
				w0_q <= prod[60:30];
			end
			S_AX_M2: begin
				w1_q <= 31'h6000_0000 - {d2, 1'b0};
			end
			S_AX_W2: begin
				wt_q[ax_q][0] <= w0_q;
				wt_q[ax_q][1] <= w1_q;
				wt_q[ax_q][2] <= prod[60:30];
				ax_q          <= ax_q + 2'd1;
			end
			S_CHK: begin
				if (!ok_q) begin
					status_q <= ST_RANGE;
				end
				gx_q <= wrap_dec(cell_q[0], nx);
				gy_q <= gy0;
				gz_q <= gz0;
				ca_q <= 2'd0;
				cb_q <= 2'd0;
				cc_q <= 2'd0;
			end
			S_C_WR: begin
				if (sat_hi || sat_lo) begin
					status_q <= ST_SAT;
				end
				wt_q[2][0] <= wt_q[2][1];
				wt_q[2][1] <= wt_q[2][2];
				wt_q[2][2] <= wt_q[2][0];
				if (cc_q != 2'd2) begin
					cc_q <= cc_q + 2'd1;
					gz_q <= wrap_inc(gz_q, nz);
				end else begin
					cc_q       <= 2'd0;
					gz_q       <= gz0;
					wt_q[1][0] <= wt_q[1][1];
					wt_q[1][1] <= wt_q[1][2];
					wt_q[1][2] <= wt_q[1][0];
					if (cb_q != 2'd2) begin
						cb_q <= cb_q + 2'd1;
						gy_q <= wrap_inc(gy_q, ny);
					end else begin
						cb_q       <= 2'd0;
						gy_q       <= gy0;
						ca_q       <= ca_q + 2'd1;
						gx_q       <= wrap_inc(gx_q, nx);
						wt_q[0][0] <= wt_q[0][1];
						wt_q[0][1] <= wt_q[0][2];
						wt_q[0][2] <= wt_q[0][0];
					end
				end
			end
			S_RD_WR: begin
				value_q <= rd_data;
			end
			default: ;
		endcase
	end

	tsc_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	tsc_ram #(
		.WIDTH (48),
		.DEPTH (DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (rd_data)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !ram_we)
		else $error("grid written outside an update step");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q == S_IDLE))
		else $error("transaction accepted while busy");

	a_cell_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_C_WR) |-> ((8'(gx_q) < 8'(nx)) && (8'(gy_q) < 8'(ny))
		&& (8'(gz_q) < 8'(nz))))
		else $error("neighbor cell outside configured grid");

	a_counters: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_C_WR) |-> (ca_q != 2'd3 && cb_q != 2'd3 && cc_q != 2'd3))
		else $error("neighbor counter out of range");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_stall) |=> out_valid)
		else $error("finished result not presented");

endmodule
`default_nettype wire

@@ verif/tsc_charge_spread_unit_tb.sv @@
// Testbench for the TSC charge spreader: directed and random transactions checked against a predictor.
`default_nettype none
module tsc_charge_spread_unit_tb;
	import tsc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM = 32;
	localparam longint LIMIT = 3000000;
	localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_MIN = -ACC_MAX - 1;
	localparam longint ONE30 = 64'sd1 << 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	tsc_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	tsc_out_t out_data;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_GRID_X;
	logic [31:0] cfg_data = '0;

	tsc_charge_spread_unit #(.GRID_DIM_MAX(DIM)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic signed [47:0] charge_grid [DIM*DIM*DIM];
	logic [5:0] size_reg [3];
	logic [31:0] inv_reg [3];
	tsc_out_t expected_results [$];
	int errors = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	longint cycles = 0;
	int last_cell [3] = '{0, 0, 0};

	function automatic int eff_size(logic [5:0] n);
		if (n < 4) return 4;
		if (n > DIM) return DIM;
		return int'(n);
	endfunction

	function automatic bit axis_weights(logic signed [31:0] pos, logic [31:0] inv, int n,
			output int cell_idx, output longint w [3]);
		longint t, v, i, u, d, d2;
		bit [63:0] vu;
		t = longint'(pos) * longint'({32'd0, inv});
		v = t + (64'sd1 << 31);
		vu = v;
		i = v >>> 32;
		u = longint'({34'd0, vu[31:2]});
		if (i < 0) i += n;
		else if (i >= n) i -= n;
		if (i < 0 || i >= n) return 1'b0;
		cell_idx = int'(i);
		d = u - (64'sd1 << 29);
		if (d < 0) d = -d;
		d2 = (d * d) >> 30;
		w[0] = ((ONE30 - u) * (ONE30 - u)) >> 30;
		w[1] = 3 * (64'sd1 << 29) - 2 * d2;
		w[2] = (u * u) >> 30;
		return 1'b1;
	endfunction

	function automatic tsc_out_t predict_cell_update(tsc_in_t x);
		tsc_out_t r;
		int n [3];
		int c [3];
		longint w [3][3];
		bit ok;
		longint q, dep, s;
		bit [63:0] qm, wxy, wt;
		int gx, gy, gz, addr;
		r = '0;
		if (x.func == FUNC_READ) begin
			addr = (int'(x.cell_x) * DIM + int'(x.cell_y)) * DIM + int'(x.cell_z);
			r.cell_value = charge_grid[addr];
			charge_grid[addr] = '0;
			return r;
		end
		q = longint'(x.charge);
		if (q == 0) return r;
		for (int k = 0; k < 3; k++) n[k] = eff_size(size_reg[k]);
		ok = axis_weights(x.pos_x, inv_reg[0], n[0], c[0], w[0]);
		ok = axis_weights(x.pos_y, inv_reg[1], n[1], c[1], w[1]) && ok;
		ok = axis_weights(x.pos_z, inv_reg[2], n[2], c[2], w[2]) && ok;
		if (!ok) begin
			r.status = ST_RANGE;
			return r;
		end
		last_cell = c;
		qm = (q < 0) ? -q : q;
		for (int a = 0; a < 3; a++) begin
			gx = (c[0] + a - 1 + n[0]) % n[0];
			for (int b = 0; b < 3; b++) begin
				gy = (c[1] + b - 1 + n[1]) % n[1];
				wxy = (w[0][a] * w[1][b]) >> 30;
				for (int e = 0; e < 3; e++) begin
					gz = (c[2] + e - 1 + n[2]) % n[2];
					wt = ((wxy * w[2][e]) >> 30) >> 3;
					dep = longint'((qm * wt) >> 30);
					if (q < 0) dep = -dep;
					addr = (gx * DIM + gy) * DIM + gz;
					s = longint'(charge_grid[addr]) + dep;
					if (s > ACC_MAX) begin
						s = ACC_MAX;
						r.status = ST_SAT;
					end else if (s < ACC_MIN) begin
						s = ACC_MIN;
						r.status = ST_SAT;
					end
					charge_grid[addr] = s[47:0];
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		tsc_out_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (out_data.cell_value !== exp_r.cell_value) begin
					$display("%0t: cell_value expected %h actual %h", $time,
						exp_r.cell_value, out_data.cell_value);
					errors++;
				end
				if (out_data.status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp_r.status, out_data.status);
					errors++;
				end
			end
		end
	end

	task automatic send_item(tsc_in_t x);
		bit idle_set;
		idle_set = 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			if (!idle_set) in_valid <= 1'b0;
			idle_set = 1'b1;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= x;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(predict_cell_update(x));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_config(logic [5:0] sx, logic [5:0] sy, logic [5:0] sz,
			logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
		logic [31:0] vals [6];
		logic [2:0] idx [6];
		vals = '{32'(sx), 32'(sy), 32'(sz), vx, vy, vz};
		idx = '{REG_GRID_X, REG_GRID_Y, REG_GRID_Z, REG_INV_X, REG_INV_Y, REG_INV_Z};
		for (int k = 0; k < 6; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= vals[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		size_reg = '{sx, sy, sz};
		inv_reg = '{vx, vy, vz};
	endtask

	function automatic tsc_in_t spread_item(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz, logic signed [31:0] q);
		tsc_in_t x;
		x = '0;
		x.func = FUNC_SPREAD;
		x.pos_x = px;
		x.pos_y = py;
		x.pos_z = pz;
		x.charge = q;
		x.cell_x = 5'($urandom);
		x.cell_y = 5'($urandom);
		x.cell_z = 5'($urandom);
		return x;
	endfunction

	function automatic tsc_in_t read_item(int cx, int cy, int cz);
		tsc_in_t x;
		x = spread_item($urandom, $urandom, $urandom, $urandom);
		x.func = FUNC_READ;
		x.cell_x = 5'(cx);
		x.cell_y = 5'(cy);
		x.cell_z = 5'(cz);
		return x;
	endfunction

	function automatic logic signed [31:0] placeable_pos(int k);
		longint n, lo, hi, span;
		bit [63:0] r;
		if (inv_reg[k] == 0) return $urandom;
		n = eff_size(size_reg[k]);
		lo = -((n << 32) / longint'({32'd0, inv_reg[k]}));
		hi = ((2 * n) << 32) / longint'({32'd0, inv_reg[k]}) - 1;
		if (lo < -(64'sd1 << 31)) lo = -(64'sd1 << 31);
		if (hi > (64'sd1 << 31) - 1) hi = (64'sd1 << 31) - 1;
		span = hi - lo + 1;
		r = {$urandom, $urandom};
		return 32'(lo + longint'(r % span));
	endfunction

	task automatic test_directed();
		send_item(spread_item(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0));
		send_item(spread_item(32'sh7FFF_FFFF, 0, 0, 32'sh0100_0000));
		send_item(spread_item(0, 32'sh8000_0000, 0, 32'sh0100_0000));
		send_item(spread_item(0, 0, 32'sh0040_0000, 32'sh0100_0000));
		send_item(spread_item(0, 0, 0, 32'sh7FFF_FFFF));
		send_item(spread_item(0, 0, 0, 32'sh8000_0000));
		send_item(spread_item(32'sh0000_8000, 32'sh0010_0000, 32'sh001F_FFFF, 32'sh7FFF_FFFF));
		send_item(spread_item(32'shFFE0_0000, 32'sh003F_FFFF, 32'shFFFF_8000, 32'sh1234_5678));
		send_item(spread_item(32'sh003F_0000, 32'shFFE0_8000, 32'sh0020_0000, 32'sh8000_0001));
		send_item(spread_item(32'sh0001_4000, 32'sh001F_8000, 32'sh0000_7FFF, 32'sh0000_0001));
		send_item(read_item(0, 0, 0));
		send_item(read_item(0, 0, 0));
		send_item(read_item(31, 31, 31));
		send_item(read_item(1, 31, 0));
		send_item(read_item(16, 16, 16));
		send_item(read_item(31, 0, 31));
		send_item(read_item(0, 31, 0));
	endtask

	task automatic test_random(int count);
		tsc_in_t x;
		int sel;
		for (int k = 0; k < count; k++) begin
			sel = $urandom_range(99);
			if (sel < 55) begin
				x = spread_item(placeable_pos(0), placeable_pos(1), placeable_pos(2), $urandom);
				if ($urandom_range(9) == 0) x.charge = 0;
				else if ($urandom_range(3) == 0) x.charge = $signed($urandom_range(2047)) - 1024;
			end else if (sel < 65) begin
				x = spread_item($urandom, $urandom, $urandom, $urandom);
			end else if (sel < 90) begin
				x = read_item((last_cell[0] + $urandom_range(2) + DIM - 1) % eff_size(size_reg[0]),
					(last_cell[1] + $urandom_range(2) + DIM - 1) % eff_size(size_reg[1]),
					(last_cell[2] + $urandom_range(2) + DIM - 1) % eff_size(size_reg[2]));
			end else begin
				x = read_item($urandom_range(31), $urandom_range(31), $urandom_range(31));
			end
			send_item(x);
		end
	endtask

	task automatic test_phase(int mode, int count);
		case (mode % 4)
			0: begin send_idle_pct = 0; stall_pct = 0; end
			1: begin send_idle_pct = 87; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 87; end
			default: begin send_idle_pct = 32; stall_pct = 32; end
		endcase
		test_random(count);
		drain();
	endtask

	initial begin
		foreach (charge_grid[k]) charge_grid[k] = '0;
		size_reg = '{6'd32, 6'd32, 6'd32};
		inv_reg = '{32'd65536, 32'd65536, 32'd65536};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_phase(0, 120);
		write_config(6'd4, 6'd4, 6'd4, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000);
		test_phase(1, 120);
		write_config(6'd0, 6'd63, 6'd17, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0002_8000);
		test_phase(2, 120);
		write_config(6'd32, 6'd5, 6'd32, 32'h0001_0000, 32'h0003_0000, 32'h0000_C000);
		test_phase(3, 120);
		write_config(6'd31, 6'd32, 6'd4, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000);
		test_phase(1, 100);
		write_config(6'd32, 6'd32, 6'd32, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		test_phase(2, 100);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire
